// File: hw/rtl/esf_pkg.sv
// ----------------------------------------------------------------------------
// esf_pkg
// shared widths, step counts and controller/datapath interface types
// ----------------------------------------------------------------------------
package esf_pkg;

   // field widths
   localparam int CX_W   = 12;   // center_x / center_y
   localparam int RX_W   = 10;   // radius_x
   localparam int RY_W   = 6;    // radius_y as received
   localparam int RYS_W  = 5;    // radius_y after saturation
   localparam int Y_W    = 6;    // signed row offset
   localparam int SPAN_W = 13;   // span coordinates

   // arithmetic widths
   localparam int R2_W   = 2 * RYS_W;        // ry^2
   localparam int RX2_W  = 2 * RX_W;         // rx^2
   localparam int PROD_W = RX2_W + R2_W;     // rx^2 * (ry^2 - y^2)
   localparam int ROOT_W = RX_W;             // half-width
   localparam int SQ_W   = RX2_W + 1;        // square root working width

   // iteration counts
   localparam int DIV_STEPS  = PROD_W;
   localparam int SQRT_STEPS = RX2_W / 2;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   // default saturation limits
   localparam int DEF_MAX_RADIUS_Y = 31;
   localparam int DEF_MAX_RADIUS_X = 1023;

   typedef struct packed {
      logic load;       // capture request
      logic setup;      // square radii, start at top row
      logic row_a;      // ry^2 - y^2
      logic row_b;      // scale by rx^2, prime divider
      logic div_step;   // one quotient bit
      logic sq_init;    // prime square root
      logic sq_step;    // one root bit
      logic emit;       // capture span, advance row
   } esf_cmd_type;

   typedef struct packed {
      logic ry_zero;
      logic last_row;
   } esf_status_type;

endpackage

// File: hw/rtl/esf_ctrl.sv
// ----------------------------------------------------------------------------
// esf_ctrl
// sequencer: steps the datapath through setup, then divide, root and emit per row
// ----------------------------------------------------------------------------
module esf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  esf_pkg::esf_status_type status,
   output esf_pkg::esf_cmd_type   cmd,
   output logic                   rsp_strobe
);
   import esf_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SETUP   = 3'd1;
   localparam logic [2:0] ST_ROW_A   = 3'd2;
   localparam logic [2:0] ST_ROW_B   = 3'd3;
   localparam logic [2:0] ST_DIV     = 3'd4;
   localparam logic [2:0] ST_SQ_INIT = 3'd5;
   localparam logic [2:0] ST_SQRT    = 3'd6;
   localparam logic [2:0] ST_EMIT    = 3'd7;

   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = status.ry_zero ? ST_EMIT : ST_ROW_A;
         end
         ST_ROW_A: begin
            cmd.row_a = 1'b1;
            state_in  = ST_ROW_B;
         end
         ST_ROW_B: begin
            cmd.row_b = 1'b1;
            cnt_in    = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SQ_INIT;
            end
         end
         ST_SQ_INIT: begin
            cmd.sq_init = 1'b1;
            cnt_in      = '0;
            state_in    = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sq_step = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit  = 1'b1;
            strobe_in = 1'b1;
            state_in  = status.last_row ? ST_IDLE : ST_ROW_A;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// File: hw/rtl/esf_dpath.sv
// ----------------------------------------------------------------------------
// esf_dpath
// span datapath: radius squares, restoring divider, bitwise square root
// ----------------------------------------------------------------------------
module esf_dpath #(
   parameter int MAX_RADIUS_Y = esf_pkg::DEF_MAX_RADIUS_Y,
   parameter int MAX_RADIUS_X = esf_pkg::DEF_MAX_RADIUS_X
) (
   input  logic                                clock,
   input  logic signed [esf_pkg::CX_W-1:0]     req_center_x,
   input  logic signed [esf_pkg::CX_W-1:0]     req_center_y,
   input  logic        [esf_pkg::RX_W-1:0]     req_radius_x,
   input  logic        [esf_pkg::RY_W-1:0]     req_radius_y,
   input  esf_pkg::esf_cmd_type                cmd,
   output esf_pkg::esf_status_type             status,
   output logic signed [esf_pkg::SPAN_W-1:0]   rsp_span_row,
   output logic signed [esf_pkg::SPAN_W-1:0]   rsp_span_left,
   output logic signed [esf_pkg::SPAN_W-1:0]   rsp_span_right,
   output logic                                rsp_last_span
);
   import esf_pkg::*;

   localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << (2 * (SQRT_STEPS - 1));

   logic signed [CX_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [RX_W-1:0]          rx_ff, rx_in;
   logic [RYS_W-1:0]         ry_ff, ry_in;
   logic signed [Y_W-1:0]    y_ff, y_in;
   logic [R2_W-1:0]          r2_ff, r2_in, diff_ff, diff_in;
   logic [RX2_W-1:0]         rx2_ff, rx2_in;
   logic [PROD_W-1:0]        dvd_ff, dvd_in;
   logic [R2_W-1:0]          rem_ff, rem_in;
   logic [SQ_W-1:0]          sv_ff, sv_in, res_ff, res_in, bit_ff, bit_in;
   logic signed [SPAN_W-1:0] row_ff, row_in, left_ff, left_in, right_ff, right_in;
   logic                     last_ff, last_in;

   logic [RX_W-1:0]   rx_sat;
   logic [RYS_W-1:0]  ry_sat;
   logic [RYS_W-1:0]  ay;
   logic [R2_W-1:0]   yy;
   logic [R2_W:0]     trial;
   logic              ge;
   logic [SQ_W-1:0]   sq_sum;
   logic [ROOT_W-1:0] hw;
   logic              last_row;

   // saturate radii at capture
   assign rx_sat = (int'(req_radius_x) > MAX_RADIUS_X) ? RX_W'(MAX_RADIUS_X) : req_radius_x;
   assign ry_sat = (int'(req_radius_y) > MAX_RADIUS_Y) ? RYS_W'(MAX_RADIUS_Y)
                                                       : req_radius_y[RYS_W-1:0];

   assign ay       = y_ff[Y_W-1] ? RYS_W'(-y_ff) : y_ff[RYS_W-1:0];
   assign yy       = ay * ay;
   assign trial    = {rem_ff, dvd_ff[PROD_W-1]};
   assign ge       = (trial >= {1'b0, r2_ff});
   assign sq_sum   = res_ff + bit_ff;
   assign last_row = (y_ff == $signed({1'b0, ry_ff}));
   assign hw       = (ry_ff == '0) ? rx_ff : res_ff[ROOT_W-1:0];

   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      y_in     = y_ff;
      r2_in    = r2_ff;
      rx2_in   = rx2_ff;
      diff_in  = diff_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      sv_in    = sv_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      right_in = right_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         cx_in = req_center_x;
         cy_in = req_center_y;
         rx_in = rx_sat;
         ry_in = ry_sat;
      end
      if (cmd.setup) begin
         rx2_in = rx_ff * rx_ff;
         r2_in  = ry_ff * ry_ff;
         y_in   = Y_W'(0) - $signed({1'b0, ry_ff});
      end
      if (cmd.row_a) begin
         diff_in = r2_ff - yy;
      end
      if (cmd.row_b) begin
         dvd_in = rx2_ff * diff_ff;
         rem_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = ge ? R2_W'(trial - {1'b0, r2_ff}) : R2_W'(trial);
         dvd_in = {dvd_ff[PROD_W-2:0], ge};
      end
      if (cmd.sq_init) begin
         sv_in  = SQ_W'(dvd_ff[RX2_W-1:0]);
         res_in = '0;
         bit_in = SQ_BIT0;
      end
      if (cmd.sq_step) begin
         if (sv_ff >= sq_sum) begin
            sv_in  = sv_ff - sq_sum;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
      if (cmd.emit) begin
         row_in   = SPAN_W'(cy_ff) + SPAN_W'(y_ff);
         left_in  = SPAN_W'(cx_ff) - $signed(SPAN_W'(hw));
         right_in = SPAN_W'(cx_ff) + $signed(SPAN_W'(hw));
         last_in  = last_row;
         y_in     = y_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      y_ff     <= y_in;
      r2_ff    <= r2_in;
      rx2_ff   <= rx2_in;
      diff_ff  <= diff_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      sv_ff    <= sv_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      row_ff   <= row_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      last_ff  <= last_in;
   end

   assign status.ry_zero  = (ry_ff == '0);
   assign status.last_row = last_row;

   assign rsp_span_row   = row_ff;
   assign rsp_span_left  = left_ff;
   assign rsp_span_right = right_ff;
   assign rsp_last_span  = last_ff;

endmodule

// File: hw/rtl/ellipse_span_filler_core.sv
// with radius_y 0 the row arithmetic is skipped and the single span is emitted right after setup
// a new start is taken only once the core is idle again, after all 2*ry + 1 rows of the last one
// per row: row setup, the restoring divider, square root setup, the square root, then emit
// busy falls as the last span strobes; the next start is taken then
// reset: synchronous, active high, returns the sequencer to idle with no strobe
// the receiver cannot stall: each span is flagged by rsp_strobe for one cycle only
// ----------------------------------------------------------------------------
// ellipse_span_filler_core
// scanline ellipse fill: one span per row, half-width via exact divide and root
// ----------------------------------------------------------------------------
module ellipse_span_filler_core #(
   parameter int MAX_RADIUS_Y = esf_pkg::DEF_MAX_RADIUS_Y,
   parameter int MAX_RADIUS_X = esf_pkg::DEF_MAX_RADIUS_X
) (
   input  logic                              clock,
   input  logic                              reset,
   // request transfer: taken when start is high and busy is low
   input  logic                              start,
   output logic                              busy,
   input  logic signed [esf_pkg::CX_W-1:0]   req_center_x,
   input  logic signed [esf_pkg::CX_W-1:0]   req_center_y,
   input  logic        [esf_pkg::RX_W-1:0]   req_radius_x,
   input  logic        [esf_pkg::RY_W-1:0]   req_radius_y,
   // span transfer: valid for the single cycle rsp_strobe is high
   output logic                              rsp_strobe,
   output logic signed [esf_pkg::SPAN_W-1:0] rsp_span_row,
   output logic signed [esf_pkg::SPAN_W-1:0] rsp_span_left,
   output logic signed [esf_pkg::SPAN_W-1:0] rsp_span_right,
   output logic                              rsp_last_span
);
   import esf_pkg::*;

   esf_cmd_type    cmd;
   esf_status_type status;

   // sequencer: one state per phase of a row, shared step counter
   esf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .status     (status),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   // datapath: request capture, row arithmetic and span output registers
   esf_dpath #(
      .MAX_RADIUS_Y (MAX_RADIUS_Y),
      .MAX_RADIUS_X (MAX_RADIUS_X)
   ) u_dpath (
      .clock          (clock),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_radius_x   (req_radius_x),
      .req_radius_y   (req_radius_y),
      .cmd            (cmd),
      .status         (status),
      .rsp_span_row   (rsp_span_row),
      .rsp_span_left  (rsp_span_left),
      .rsp_span_right (rsp_span_right),
      .rsp_last_span  (rsp_last_span)
   );

endmodule

// File: hw/rtl/esf_checker.sv
// ----------------------------------------------------------------------------
// esf_checker
// port-level checks on request and span transfers, bound to the core
// ----------------------------------------------------------------------------
module esf_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last_span
);

   // an accepted request makes the core busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after request transfer");

   // no span directly after a request is taken
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("span strobe right after request transfer");

   // spans are never back to back
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back to back span strobes");

   // more spans pending keeps the core busy
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_span) |-> busy)
      else $error("core idle before last span");

   // a span only comes out of a busy core or right at its end
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(busy)) |-> 1'b0)
      else $error("span strobe from an idle core");

endmodule

bind ellipse_span_filler_core esf_checker u_esf_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_last_span (rsp_last_span)
);
